@@ rtl/core/tse_pkg.sv @@
// ---------------------------------------------------------------------------
// tse_pkg: shared constants and types
// Widths, fixed-point scales and divider sizing for the Taylor-series
// exponential block.
// ---------------------------------------------------------------------------
package tse_pkg;

   // Payload widths
   localparam int A_W   = 16;   // exponent, signed Q3.12
   localparam int K_W   = 5;    // last term index
   localparam int TERM_W = 32;  // terms and sum, signed

   // Fraction bits of the exponent (divide by 4096)
   localparam int A_FRACTION_BITS = 12;

   // Parameter defaults for the top level
   localparam int MAX_TERM_INDEX_DEFAULT = 20;
   localparam int FRACTION_BITS_DEFAULT  = 16;

   // term * a product and the pre-shifted dividend
   localparam int PROD_W = TERM_W + A_W;
   localparam int DIV_W  = PROD_W - A_FRACTION_BITS;

   // Divider retires this many quotient bits per cycle
   localparam int DIV_STEP_BITS = 6;
   localparam int DIV_CYCLES    = (DIV_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
   localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

   localparam logic signed [TERM_W-1:0] TERM_MAX = {1'b0, {(TERM_W-1){1'b1}}};
   localparam logic signed [TERM_W-1:0] TERM_MIN = {1'b1, {(TERM_W-1){1'b0}}};

   // Divider status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

@@ rtl/core/tse_req_if.sv @@
// ---------------------------------------------------------------------------
// tse_req_if: request channel
// Valid/ready channel carrying the exponent and the last term index.
// ---------------------------------------------------------------------------
interface tse_req_if;
   logic                          valid;
   logic                          ready;
   logic signed [tse_pkg::A_W-1:0] a_value;
   logic [tse_pkg::K_W-1:0]        last_term_index;

   modport source (output valid, output a_value, output last_term_index, input ready);
   modport sink   (input valid, input a_value, input last_term_index, output ready);
endinterface

@@ rtl/core/tse_rsp_if.sv @@
// ---------------------------------------------------------------------------
// tse_rsp_if: response channel
// Valid/ready channel carrying the series sum and the saturation flag.
// ---------------------------------------------------------------------------
interface tse_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [tse_pkg::TERM_W-1:0] sum_value;
   logic                              saturated;

   modport source (output valid, output sum_value, output saturated, input ready);
   modport sink   (input valid, input sum_value, input saturated, output ready);
endinterface

@@ rtl/core/tse_div.sv @@
// ---------------------------------------------------------------------------
// tse_div: multi-cycle unsigned divider
// Divides a wide dividend by a small term index, retiring several
// restoring-division bits per cycle. Quotient holds until the next start.
// ---------------------------------------------------------------------------
module tse_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [tse_pkg::DIV_W-1:0]      dividend,
   input  logic [tse_pkg::K_W-1:0]        divisor,
   output logic [tse_pkg::DIV_W-1:0]      quotient,
   output tse_pkg::div_stat_type          stat
);

   logic [tse_pkg::DIV_W-1:0]     dvd_ff, dvd_in;
   logic [tse_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [tse_pkg::K_W-1:0]       rem_ff, rem_in;
   logic [tse_pkg::K_W-1:0]       dsr_ff;
   logic [tse_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                          busy_ff;
   logic                          done_ff;

   // Several dependent compare/subtract steps on the narrow remainder
   always_comb begin
      logic [tse_pkg::K_W:0] trial;
      logic                  qbit;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      for (int i = 0; i < tse_pkg::DIV_STEP_BITS; i++) begin
         trial  = {rem_in, dvd_in[tse_pkg::DIV_W-1]};
         dvd_in = {dvd_in[tse_pkg::DIV_W-2:0], 1'b0};
         qbit   = (trial >= {1'b0, dsr_ff});
         if (qbit) begin
            trial = trial - {1'b0, dsr_ff};
         end
         rem_in = trial[tse_pkg::K_W-1:0];
         quo_in = {quo_in[tse_pkg::DIV_W-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + tse_pkg::DIV_CNT_W'(1);
            if (cnt_ff == tse_pkg::DIV_CNT_W'(tse_pkg::DIV_CYCLES - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ rtl/core/taylor_series_exponential.sv @@
// ---------------------------------------------------------------------------
// taylor_series_exponential: truncated Maclaurin series for e^a
// Sums a^n/n! for n = 0..k in fixed point with one shared multiplier and
// one shared multi-cycle divider under a small sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   req_ch carries a_value (signed Q3.12) and last_term_index k; a beat is
//   taken only while the block is idle. Indexes above MAX_TERM_INDEX are
//   clamped to it.
//   rsp_ch returns sum_value (signed, FRACTION_BITS fraction bits) and
//   saturated, raised if any term or partial sum clipped to 32 bits.
// Sequence:
//   Each term passes through a multiply step, a round/prepare step, the
//   divider's iterations plus a handoff, and an accumulate step. At k = 0
//   rsp valid rises in the cycle after the request beat. One item is in
//   flight at a time: a new request beat is taken only after the receiver
//   has taken the previous response.
// Reset:
//   Synchronous reset returns the sequencer to idle, drops rsp valid and
//   aborts any item in progress.
// Stall:
//   A finished result waits in the output registers with rsp valid high
//   until the receiver takes it; no new request is taken meanwhile.
// ---------------------------------------------------------------------------
module taylor_series_exponential #(
   parameter int MAX_TERM_INDEX = tse_pkg::MAX_TERM_INDEX_DEFAULT,
   parameter int FRACTION_BITS  = tse_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   tse_req_if.sink   req_ch,
   tse_rsp_if.source rsp_ch
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_PREP,
      ST_DIV,
      ST_ACC,
      ST_DONE
   } state_type;

   state_type                           state_ff;
   logic signed [tse_pkg::A_W-1:0]      a_ff;
   logic [tse_pkg::K_W-1:0]             k_ff, k_in;
   logic [tse_pkg::K_W-1:0]             n_ff;
   logic signed [tse_pkg::TERM_W-1:0]   term_ff, term_in;
   logic signed [tse_pkg::TERM_W-1:0]   sum_ff, sum_in;
   logic                                sat_ff, sat_in;
   logic signed [tse_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic                                neg_ff;

   logic [tse_pkg::PROD_W-1:0]          mag;
   logic [tse_pkg::PROD_W-1:0]          rnd;
   logic [tse_pkg::DIV_W-1:0]           div_dividend;
   logic [tse_pkg::DIV_W-1:0]           div_quotient;
   logic                                div_start;
   tse_pkg::div_stat_type               div_stat;
   logic                                term_sat;
   logic signed [tse_pkg::TERM_W:0]     sum_wide;

   localparam logic [tse_pkg::DIV_W-1:0] POS_LIMIT =
      tse_pkg::DIV_W'({1'b0, tse_pkg::TERM_MAX});
   localparam logic [tse_pkg::DIV_W-1:0] NEG_LIMIT =
      tse_pkg::DIV_W'(1) << (tse_pkg::TERM_W - 1);
   localparam logic signed [tse_pkg::TERM_W-1:0] TERM_ONE =
      tse_pkg::TERM_W'(1) << FRACTION_BITS;

   // Clamp the requested index
   assign k_in = (req_ch.last_term_index > tse_pkg::K_W'(MAX_TERM_INDEX)) ?
                 tse_pkg::K_W'(MAX_TERM_INDEX) : req_ch.last_term_index;

   // Shared multiplier: previous term times a
   assign prod_in = term_ff * a_ff;

   // Round to nearest, ties away: |p| + 2048*n, then floor by 4096*n.
   // The 4096 goes out as a shift, the n through the divider.
   assign mag = prod_ff[tse_pkg::PROD_W-1] ? tse_pkg::PROD_W'(-prod_ff) :
                tse_pkg::PROD_W'(prod_ff);
   assign rnd = mag + (tse_pkg::PROD_W'(n_ff) << (tse_pkg::A_FRACTION_BITS - 1));
   assign div_dividend = rnd[tse_pkg::PROD_W-1 -: tse_pkg::DIV_W];
   assign div_start    = (state_ff == ST_PREP);

   tse_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (n_ff),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   // Re-apply sign and clip the new term, then accumulate with clipping
   always_comb begin
      term_sat = 1'b0;
      if (!neg_ff) begin
         if (div_quotient > POS_LIMIT) begin
            term_in  = tse_pkg::TERM_MAX;
            term_sat = 1'b1;
         end else begin
            term_in = $signed(div_quotient[tse_pkg::TERM_W-1:0]);
         end
      end else begin
         if (div_quotient > NEG_LIMIT) begin
            term_in  = tse_pkg::TERM_MIN;
            term_sat = 1'b1;
         end else begin
            term_in = -$signed(div_quotient[tse_pkg::TERM_W-1:0]);
         end
      end

      sum_wide = {sum_ff[tse_pkg::TERM_W-1], sum_ff} +
                 {term_in[tse_pkg::TERM_W-1], term_in};
      sat_in   = sat_ff | term_sat;
      // top two bits disagree: out of 32-bit range
      if (sum_wide[tse_pkg::TERM_W] != sum_wide[tse_pkg::TERM_W-1]) begin
         sum_in = sum_wide[tse_pkg::TERM_W] ? tse_pkg::TERM_MIN : tse_pkg::TERM_MAX;
         sat_in = 1'b1;
      end else begin
         sum_in = sum_wide[tse_pkg::TERM_W-1:0];
      end
   end

   // Sequencer and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  a_ff    <= req_ch.a_value;
                  k_ff    <= k_in;
                  n_ff    <= tse_pkg::K_W'(1);
                  term_ff <= TERM_ONE;
                  sum_ff  <= TERM_ONE;
                  sat_ff  <= 1'b0;
                  state_ff <= (k_in == '0) ? ST_DONE : ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= ST_PREP;
            end
            ST_PREP: begin
               neg_ff   <= prod_ff[tse_pkg::PROD_W-1];
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_stat.done) begin
                  state_ff <= ST_ACC;
               end
            end
            ST_ACC: begin
               term_ff <= term_in;
               sum_ff  <= sum_in;
               sat_ff  <= sat_in;
               if (n_ff == k_ff) begin
                  state_ff <= ST_DONE;
               end else begin
                  n_ff     <= n_ff + tse_pkg::K_W'(1);
                  state_ff <= ST_MUL;
               end
            end
            ST_DONE: begin
               if (rsp_ch.ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = (state_ff == ST_DONE);
   assign rsp_ch.sum_value = sum_ff;
   assign rsp_ch.saturated = sat_ff;

`ifndef SYNTHESIS
   // Request and response sides never open at once
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request ready while response valid");

   // Divider only finishes while the sequencer waits for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider done outside wait state");

   // Divider is never restarted mid-division
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   // Term index stays within 1..k while accumulating
   a_term_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC) |-> ((n_ff != '0) && (n_ff <= k_ff)))
      else $error("term index out of range");
`endif

endmodule
